[design/assert_macros.svh]
// Assertion helpers; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Consequence of a condition, checked in the cycle after it.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_AT(lbl, clk, rst, prop)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[design/dad_pkg.sv]
package dad_pkg;

  // Position classes
  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_POS  = 2'd1,
    CLS_NEG  = 2'd2
  } cls_t;

  // Item functions
  typedef enum logic [1:0] {
    FN_SAMPLE     = 2'd0,
    FN_IMPULSE    = 2'd1,
    FN_TAKE_FLAG  = 2'd2,
    FN_TAKE_COUNT = 2'd3
  } func_t;

  localparam logic signed [15:0] HALF_POS     = 16'sd8192;
  localparam logic signed [15:0] FULL_POS     = 16'sd16384;
  localparam logic [14:0]        COUNT_MAX    = 15'h7FFF;
  localparam logic [10:0]        THRESH_RESET = 11'd300;

  typedef struct packed {
    func_t              func;
    logic [3:0]         player;
    logic [5:0]         control_index;
    logic signed [15:0] position;
    logic [31:0]        now_ms;
  } req_t;

  typedef struct packed {
    logic        double_fired;
    logic        fired_polarity;
    logic        flag_taken;
    logic [14:0] count_taken;
  } rsp_t;

  // One table entry, 52 bits
  typedef struct packed {
    logic        triggered;
    logic [31:0] click_time;
    cls_t        last_cls;
    cls_t        click_cls;
    logic [14:0] count;
  } entry_t;

endpackage

[design/double_activation_detector_top.sv]
// Double-activation detector table, one entry per (player, control).
// Command channel: req is taken at a rising edge with start high and busy low.
// Every transaction yields one result on result, marked by done for exactly
// one cycle; the receiver cannot stall it and need not acknowledge.
// The accepting edge reads the entry and registers the item, entering S_EXEC;
// the edge that leaves S_EXEC updates the entry, writes it back and
// registers the result with done.
// A new transaction is not taken before the last one is written back:
// busy is high in S_EXEC, between the accept and the write-back.
// Items whose player or control lies outside the table return all zeros.
// Reset: the entry memory is swept to zero, one entry per cycle, through all
// PLAYERS*CONTROLS entries with busy high; threshold returns to 300.
// cfg_we/cfg_wdata write the threshold; write it while idle.
`include "assert_macros.svh"

module double_activation_detector_top #(
  parameter int PLAYERS  = 16,
  parameter int CONTROLS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  dad_pkg::req_t  req,
  output logic           done,
  output dad_pkg::rsp_t  result,
  input  logic           cfg_we,
  input  logic [10:0]    cfg_wdata
);

  localparam int DEPTH = PLAYERS * CONTROLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t          state;
  logic [AW-1:0]   clr_addr;
  logic [10:0]     threshold;
  dad_pkg::req_t   item;
  logic            item_in_range;
  logic [AW-1:0]   item_addr;

  logic            accept;
  logic            req_in_range;
  logic [AW-1:0]   req_addr;

  dad_pkg::entry_t mem [DEPTH];
  dad_pkg::entry_t rd_entry;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  dad_pkg::entry_t mem_wdata;

  dad_pkg::entry_t nxt_entry;
  dad_pkg::rsp_t   upd_rsp;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Table address of the incoming transaction
  assign req_in_range = (32'(req.player) < PLAYERS) && (32'(req.control_index) < CONTROLS);
  assign req_addr     = AW'(32'(req.player) * CONTROLS + 32'(req.control_index));

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= dad_pkg::THRESH_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  // Entry update
  dad_update u_update (
    .cur       (rd_entry),
    .item      (item),
    .threshold (threshold),
    .nxt       (nxt_entry),
    .rsp       (upd_rsp)
  );

  // Write port: clearing sweep or write-back
  always_comb begin
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = (state == S_EXEC) && item_in_range;
      mem_waddr = item_addr;
      mem_wdata = nxt_entry;
    end
  end

  // Entry memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept && req_in_range) begin
      rd_entry <= mem[req_addr];
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            state         <= S_EXEC;
            item          <= req;
            item_in_range <= req_in_range;
            item_addr     <= req_addr;
          end
        end
        S_EXEC: begin
          state  <= S_IDLE;
          done   <= 1'b1;
          result <= item_in_range ? upd_rsp : '0;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_AT(a_done_after_exec, clk, rst, done |-> $past(state == S_EXEC))
  `ASSERT_NEXT(a_accept_to_exec, clk, rst, accept, state == S_EXEC)
  `ASSERT_NEXT(a_clear_ends, clk, rst, state == S_CLEAR && clr_addr == LAST_ADDR, !busy)
  `ASSERT_AT(a_polarity_fired, clk, rst, (done && result.fired_polarity) |-> result.double_fired)

endmodule

[design/dad_update.sv]
// Read-modify step for one table entry.
module dad_update (
  input  dad_pkg::entry_t cur,
  input  dad_pkg::req_t   item,
  input  logic [10:0]     threshold,
  output dad_pkg::entry_t nxt,
  output dad_pkg::rsp_t   rsp
);

  typedef struct packed {
    dad_pkg::entry_t e;
    logic            fired;
    logic            neg;
  } samp_t;

  // Class of a position sample; exactly +-0.5 counts as released
  function automatic dad_pkg::cls_t classify(logic signed [15:0] pos);
    dad_pkg::cls_t c;
    if (pos > dad_pkg::HALF_POS) begin
      c = dad_pkg::CLS_POS;
    end else if (pos < -dad_pkg::HALF_POS) begin
      c = dad_pkg::CLS_NEG;
    end else begin
      c = dad_pkg::CLS_NONE;
    end
    return c;
  endfunction

  // One sample applied to an entry
  function automatic samp_t sample(dad_pkg::entry_t e, dad_pkg::cls_t cls,
                                   logic [31:0] now, logic [10:0] thr);
    samp_t       s;
    logic [31:0] diff;
    s.e     = e;
    s.fired = 1'b0;
    s.neg   = 1'b0;
    diff    = now - e.click_time;
    if (thr == '0) begin
      // detection off: forget the click and clear the flag, keep the last class
      s.e.triggered  = 1'b0;
      s.e.click_time = '0;
      s.e.click_cls  = dad_pkg::CLS_NONE;
    end else if (cls == dad_pkg::CLS_NONE) begin
      s.e.last_cls = dad_pkg::CLS_NONE;
    end else if (cls != e.last_cls) begin
      if (cls == e.click_cls && diff < {21'd0, thr}) begin
        s.e.triggered = 1'b1;
        s.fired       = 1'b1;
        s.neg         = (cls == dad_pkg::CLS_NEG);
      end
      s.e.click_time = now;
      s.e.click_cls  = cls;
      s.e.last_cls   = cls;
    end
    return s;
  endfunction

  samp_t           s_pos;
  samp_t           s_rel;
  samp_t           s_smp;
  dad_pkg::entry_t cur_inc;

  // Saturating impulse count
  always_comb begin
    cur_inc = cur;
    if (cur.count != dad_pkg::COUNT_MAX) begin
      cur_inc.count = cur.count + 15'd1;
    end
  end

  assign s_smp = sample(cur, classify(item.position), item.now_ms, threshold);
  assign s_pos = sample(cur_inc, classify(dad_pkg::FULL_POS), item.now_ms, threshold);
  assign s_rel = sample(s_pos.e, dad_pkg::CLS_NONE, item.now_ms, threshold);

  // Select by function
  always_comb begin
    nxt = cur;
    rsp = '0;
    case (item.func)
      dad_pkg::FN_SAMPLE: begin
        nxt                = s_smp.e;
        rsp.double_fired   = s_smp.fired;
        rsp.fired_polarity = s_smp.fired & s_smp.neg;
      end
      dad_pkg::FN_IMPULSE: begin
        nxt                = s_rel.e;
        rsp.double_fired   = s_pos.fired;
        rsp.fired_polarity = s_pos.fired & s_pos.neg;
      end
      dad_pkg::FN_TAKE_FLAG: begin
        nxt.triggered  = 1'b0;
        rsp.flag_taken = cur.triggered;
      end
      dad_pkg::FN_TAKE_COUNT: begin
        nxt.count       = '0;
        rsp.count_taken = cur.count;
      end
      default: begin
        nxt = cur;
        rsp = '0;
      end
    endcase
  end

endmodule
